// ===== sv/m4inv_pkg.sv =====
// ----------------------------------------------------------------------------
// m4inv_pkg
// Shared types, constants and index helpers for the 4x4 adjugate inverse.
// ----------------------------------------------------------------------------
`default_nettype none

package m4inv_pkg;

   localparam int VALUE_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;
   // A cofactor magnitude always fits in four element-wide chunks.
   localparam int NUM_CHUNKS      = 4;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_TRIP_X,
      ST_TRIP_Y,
      ST_TRIP_Z,
      ST_CHUNK,
      ST_COF_WR,
      ST_DET_SET,
      ST_DET_WR,
      ST_DIV_INIT,
      ST_DIV_WAIT,
      ST_ROUND,
      ST_SAT,
      ST_OUT
   } state_type;

   // Store address of operand s of Sarrus term t of the 3x3 minor that
   // belongs to adjugate entry k (row k[1:0], column k[3:2]).
   function automatic logic [3:0] trip_addr(input logic [3:0] k, input logic [2:0] t,
                                             input logic [1:0] s);
      logic [5:0] perm;
      logic [1:0] p;
      logic [1:0] r;
      logic [1:0] c;
      logic [1:0] row;
      logic [1:0] col;
      r = k[1:0];
      c = k[3:2];
      unique case (t)
         3'd0:    perm = {2'd2, 2'd1, 2'd0};
         3'd1:    perm = {2'd1, 2'd2, 2'd0};
         3'd2:    perm = {2'd2, 2'd0, 2'd1};
         3'd3:    perm = {2'd0, 2'd2, 2'd1};
         3'd4:    perm = {2'd1, 2'd0, 2'd2};
         3'd5:    perm = {2'd0, 2'd1, 2'd2};
         default: perm = {2'd2, 2'd1, 2'd0};
      endcase
      p   = perm[2*s +: 2];
      row = (s < c) ? s : s + 2'd1;
      col = (p < r) ? p : p + 2'd1;
      return {col, row};
   endfunction

   function automatic logic term_neg(input logic [2:0] t);
      return (t == 3'd1) || (t == 3'd2) || (t == 3'd5);
   endfunction

endpackage

`default_nettype wire

// ===== sv/mat4_inverse_adjugate_top.sv =====
// ----------------------------------------------------------------------------
// mat4_inverse_adjugate_top
// 4x4 fixed-point matrix inverse by adjugate and determinant.
// ----------------------------------------------------------------------------
//  Channel | Ports                                   | Direction
//  req     | req_valid, req_ready, req_elem_value    | in, column-major
//  rsp     | rsp_valid, rsp_ready, rsp_inv_value,    | out, column-major
//          | rsp_singular, rsp_saturated, rsp_last_of_run
//
// Sixteen element transfers load the store, one per cycle. One shared multiplier
// then forms 96 triple products plus the determinant, and a bit-serial divider
// forms each result, skipped when the matrix is singular. req_ready is low from
// the sixteenth element until the last result is taken; a stalled rsp holds the
// sequencer. Reset clears the sequencer and load count.
// ----------------------------------------------------------------------------
`default_nettype none

module mat4_inverse_adjugate_top #(
   parameter int VALUE_WIDTH = m4inv_pkg::VALUE_WIDTH_DEF,
   parameter int FRAC_BITS   = m4inv_pkg::FRAC_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_elem_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_inv_value,
   output logic             rsp_singular,
   output logic             rsp_saturated,
   output logic             rsp_last_of_run
);

   import m4inv_pkg::*;

   localparam int EW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
   localparam int CW = 3 * EW + 2;
   localparam int DW = 4 * EW + 2;
   localparam int MW = NUM_CHUNKS * EW;
   localparam int NW = CW + 2 * FRAC_BITS;
   localparam logic [NW:0] LIM_POS = ({{NW{1'b0}}, 1'b1} << (VALUE_WIDTH - 1)) - 1'b1;
   localparam logic [NW:0] LIM_NEG = LIM_POS + 1'b1;

   function automatic logic [EW-1:0] mag_e(input logic [EW-1:0] v);
      return v[EW-1] ? (~v + 1'b1) : v;
   endfunction

   function automatic logic [CW-1:0] mag_c(input logic [CW-1:0] v);
      return v[CW-1] ? (~v + 1'b1) : v;
   endfunction

   state_type state_ff, state_in;

   logic [EW-1:0]   store_ff [16];
   logic [CW-1:0]   cof_ff [16];
   logic [3:0]      load_cnt_ff;
   logic [3:0]      k_ff;
   logic [2:0]      t_ff;
   logic [2:0]      j_ff;
   logic            det_mode_ff;

   logic [EW-1:0]   xmag_ff;
   logic [EW-1:0]   opb_ff;
   logic [MW-1:0]   opa_ff;
   logic [2*EW-1:0] prod_ff;
   logic            neg_ff;
   logic [DW-1:0]   acc_ff;
   logic [DW-1:0]   dmag_ff;
   logic            det_zero_ff;
   logic            det_neg_ff;
   logic            negq_ff;
   logic [NW:0]     q_ff;

   logic [31:0]     rsp_value_ff;
   logic            rsp_sing_ff;
   logic            rsp_sat_ff;
   logic            rsp_last_ff;

   logic            req_fire;
   logic [3:0]      rd_addr;
   logic [EW-1:0]   rd_elem;
   logic [2:0]      chunk_lim;
   logic [DW-1:0]   shifted;
   logic            div_start;
   logic            div_done;
   logic [NW-1:0]   div_quot;
   logic            div_round;
   logic [NW-1:0]   div_numer;
   logic            sat;
   logic [NW:0]     res;

   assign req_fire  = req_valid && req_ready;
   assign chunk_lim = det_mode_ff ? 3'(NUM_CHUNKS) : 3'd2;
   assign rd_elem   = store_ff[rd_addr];
   assign shifted   = DW'(prod_ff) << (EW * int'(j_ff - 3'd1));
   assign div_numer = NW'(mag_c(cof_ff[k_ff])) << (2 * FRAC_BITS);

   always_comb begin
      unique case (state_ff)
         ST_TRIP_Y:  rd_addr = trip_addr(k_ff, t_ff, 2'd1);
         ST_TRIP_Z:  rd_addr = trip_addr(k_ff, t_ff, 2'd2);
         ST_DET_SET: rd_addr = {k_ff[1:0], 2'b00};
         default:    rd_addr = trip_addr(k_ff, t_ff, 2'd0);
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid && (load_cnt_ff == 4'd15)) state_in = ST_TRIP_X;
         end
         ST_TRIP_X:  state_in = ST_TRIP_Y;
         ST_TRIP_Y:  state_in = ST_TRIP_Z;
         ST_TRIP_Z:  state_in = ST_CHUNK;
         ST_CHUNK: begin
            if (j_ff == chunk_lim) begin
               if (det_mode_ff) begin
                  state_in = (k_ff == 4'd3) ? ST_DET_WR : ST_DET_SET;
               end else begin
                  state_in = (t_ff == 3'd5) ? ST_COF_WR : ST_TRIP_X;
               end
            end
         end
         ST_COF_WR:  state_in = (k_ff == 4'd15) ? ST_DET_SET : ST_TRIP_X;
         ST_DET_SET: state_in = ST_CHUNK;
         ST_DET_WR:  state_in = ST_DIV_INIT;
         ST_DIV_INIT: begin
            if (det_zero_ff) begin
               state_in = ST_OUT;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV_WAIT;
            end
         end
         ST_DIV_WAIT: if (div_done) state_in = ST_ROUND;
         ST_ROUND:   state_in = ST_SAT;
         ST_SAT:     state_in = ST_OUT;
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = (k_ff == 4'd15) ? ST_LOAD : ST_DIV_INIT;
         end
         default:    state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequencer counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         load_cnt_ff <= '0;
         k_ff        <= '0;
         t_ff        <= '0;
         j_ff        <= '0;
         det_mode_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_LOAD: begin
               if (req_fire) load_cnt_ff <= load_cnt_ff + 1'b1;
               k_ff <= '0;
               t_ff <= '0;
            end
            ST_TRIP_Z: begin
               j_ff        <= '0;
               det_mode_ff <= 1'b0;
            end
            ST_CHUNK: begin
               j_ff <= j_ff + 1'b1;
               if (j_ff == chunk_lim) begin
                  if (det_mode_ff) k_ff <= k_ff + 1'b1;
                  else t_ff <= t_ff + 1'b1;
               end
            end
            ST_COF_WR: begin
               t_ff <= '0;
               k_ff <= k_ff + 1'b1;
            end
            ST_DET_SET: begin
               j_ff        <= '0;
               det_mode_ff <= 1'b1;
            end
            ST_DET_WR:  k_ff <= '0;
            ST_OUT:     if (rsp_ready) k_ff <= k_ff + 1'b1;
            default: begin
            end
         endcase
      end
   end

   // Element store, shared multiplier, accumulator and result formatting.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire) store_ff[load_cnt_ff] <= req_elem_value[EW-1:0];
            acc_ff <= '0;
         end
         ST_TRIP_X: begin
            xmag_ff <= mag_e(rd_elem);
            neg_ff  <= rd_elem[EW-1] ^ term_neg(t_ff) ^ k_ff[0] ^ k_ff[2];
         end
         ST_TRIP_Y: begin
            prod_ff <= (2*EW)'(xmag_ff) * (2*EW)'(mag_e(rd_elem));
            neg_ff  <= neg_ff ^ rd_elem[EW-1];
         end
         ST_TRIP_Z: begin
            opb_ff <= mag_e(rd_elem);
            neg_ff <= neg_ff ^ rd_elem[EW-1];
            opa_ff <= MW'(prod_ff);
         end
         ST_CHUNK: begin
            if (j_ff < chunk_lim) begin
               prod_ff <= (2*EW)'(opa_ff[j_ff[1:0]*EW +: EW]) * (2*EW)'(opb_ff);
            end
            // The accumulator takes the product of the previous chunk, registered in prod_ff.
            if (j_ff != 3'd0) acc_ff <= neg_ff ? acc_ff - shifted : acc_ff + shifted;
         end
         ST_COF_WR: begin
            cof_ff[k_ff] <= acc_ff[CW-1:0];
            acc_ff       <= '0;
         end
         ST_DET_SET: begin
            opb_ff <= mag_e(rd_elem);
            opa_ff <= MW'(mag_c(cof_ff[k_ff]));
            neg_ff <= rd_elem[EW-1] ^ cof_ff[k_ff][CW-1];
         end
         ST_DET_WR: begin
            det_zero_ff <= (acc_ff == '0);
            det_neg_ff  <= acc_ff[DW-1];
            dmag_ff     <= acc_ff[DW-1] ? (~acc_ff + 1'b1) : acc_ff;
         end
         ST_DIV_INIT: begin
            negq_ff      <= cof_ff[k_ff][CW-1] ^ det_neg_ff;
            rsp_value_ff <= '0;
            rsp_sing_ff  <= 1'b1;
            rsp_sat_ff   <= 1'b0;
            rsp_last_ff  <= (k_ff == 4'd15);
         end
         ST_ROUND: q_ff <= (NW+1)'(div_quot) + (NW+1)'(div_round);
         ST_SAT: begin
            rsp_value_ff <= res[31:0];
            rsp_sing_ff  <= 1'b0;
            rsp_sat_ff   <= sat;
         end
         default: begin
         end
      endcase
   end

   assign sat = negq_ff ? (q_ff > LIM_NEG) : (q_ff > LIM_POS);

   always_comb begin
      if (sat) res = negq_ff ? (~LIM_NEG + 1'b1) : LIM_POS;
      else     res = negq_ff ? (~q_ff + 1'b1) : q_ff;
   end

   m4inv_divider #(
      .NUM_W (NW),
      .DEN_W (DW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (div_numer),
      .denom    (dmag_ff),
      .done     (div_done),
      .quot     (div_quot),
      .round_up (div_round)
   );

   assign rsp_inv_value   = rsp_value_ff;
   assign rsp_singular    = rsp_sing_ff;
   assign rsp_saturated   = rsp_sat_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

`default_nettype wire

// ===== sv/m4inv_divider.sv =====
// ----------------------------------------------------------------------------
// m4inv_divider
// Restoring unsigned divider, one quotient bit per cycle, with a round flag.
// ----------------------------------------------------------------------------
`default_nettype none

module m4inv_divider #(
   parameter int NUM_W = 130,
   parameter int DEN_W = 130
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] numer,
   input  wire logic [DEN_W-1:0] denom,
   output logic                  done,
   output logic [NUM_W-1:0]      quot,
   output logic                  round_up
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             ge;

   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= numer;
         rem_ff <= '0;
         den_ff <= denom;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_ff <= {quo_ff[NUM_W-2:0], ge};
      end
   end

   assign done     = done_ff;
   assign quot     = quo_ff;
   // Round half away from zero: twice the remainder reaches the divisor.
   assign round_up = {rem_ff, 1'b0} >= {1'b0, den_ff};

endmodule

`default_nettype wire
